// ----- hw/rtl/uart8n1_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// uart8n1_pkg
// Shared types and constants for the 8N1 transceiver with receive ring buffer.
// ----------------------------------------------------------------------------
package uart8n1_pkg;

   // opcodes carried with each tick
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_POP   = 2'd2;
   localparam logic [1:0] OP_PEEK  = 2'd3;

   // configuration register indexes
   localparam logic CSR_BIT_PERIOD = 1'b0;
   localparam logic CSR_RX_ENABLE  = 1'b1;

   localparam logic [15:0] BIT_PERIOD_RESET = 16'd1667;

   // input beat
   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] tx_byte;
      logic       rx_level;
   } req_type;

   // result beat
   typedef struct packed {
      logic       tx_line;
      logic [7:0] read_data;
      logic       read_valid;
      logic [5:0] rx_count;
      logic       overflow;
      logic       write_accepted;
   } rsp_type;

   // receiver to buffer: byte completed this tick
   typedef struct packed {
      logic       push;
      logic [7:0] data;
   } rx_push_type;

   // transmitter status for this tick
   typedef struct packed {
      logic line;
      logic accepted;
   } tx_status_type;

   // a wait that would be zero ticks lasts one tick
   function automatic logic [16:0] at_least_one(input logic [16:0] v);
      at_least_one = (v == 17'd0) ? 17'd1 : v;
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/uart8n1_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// uart8n1_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module uart8n1_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire                       clock,
   input  wire                       we,
   input  wire [$clog2(DEPTH)-1:0]   waddr,
   input  wire [WIDTH-1:0]           wdata,
   input  wire                       re,
   input  wire [$clog2(DEPTH)-1:0]   raddr,
   output logic [WIDTH-1:0]          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // read port, data held while not enabled
   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/uart8n1_rx.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// uart8n1_rx
// Receiver: start edge detect, mid-bit sampling of eight data bits, re-arm.
// ----------------------------------------------------------------------------
module uart8n1_rx
   import uart8n1_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          enable,
   input  wire          rx_level,
   input  wire [15:0]   bit_period,
   input  wire          rx_enable,
   output rx_push_type  push_out
);

   localparam logic [1:0] RX_IDLE  = 2'd0;
   localparam logic [1:0] RX_START = 2'd1;
   localparam logic [1:0] RX_DATA  = 2'd2;
   localparam logic [1:0] RX_STOP  = 2'd3;

   logic        prev_ff, prev_in;
   logic [1:0]  phase_ff, phase_in;
   logic [16:0] cnt_ff, cnt_in;
   logic [3:0]  idx_ff, idx_in;
   logic [7:0]  shift_ff, shift_in;
   logic        push_c;

   logic [16:0] start_wait;
   logic [17:0] three_bp;
   logic [16:0] stop_wait;
   logic [16:0] bit_wait;
   logic [16:0] cnt_dec;

   // wait lengths from the bit period
   assign start_wait = {1'b0, bit_period} + {2'b0, bit_period[15:1]};
   assign three_bp   = {2'b0, bit_period} + {1'b0, bit_period, 1'b0};
   assign stop_wait  = {1'b0, three_bp[17:2]};
   assign bit_wait   = {1'b0, bit_period};
   assign cnt_dec    = cnt_ff - 17'd1;

   // next state of the receive sequencer
   always_comb begin
      prev_in  = rx_level;
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      shift_in = shift_ff;
      push_c   = 1'b0;
      case (phase_ff)
         RX_IDLE: begin
            if (rx_enable && prev_ff && !rx_level) begin
               phase_in = RX_START;
               cnt_in   = at_least_one(start_wait);
               idx_in   = 4'd0;
               shift_in = 8'd0;
            end
         end
         RX_START, RX_DATA: begin
            cnt_in = cnt_dec;
            if (cnt_dec == 17'd0) begin
               shift_in = {rx_level, shift_ff[7:1]};
               idx_in   = idx_ff + 4'd1;
               if (idx_in >= 4'd8) begin
                  push_c   = 1'b1;
                  phase_in = RX_STOP;
                  cnt_in   = at_least_one(stop_wait);
               end else begin
                  phase_in = RX_DATA;
                  cnt_in   = at_least_one(bit_wait);
               end
            end
         end
         default: begin
            cnt_in = cnt_dec;
            if (cnt_dec == 17'd0) begin
               phase_in = RX_IDLE;
            end
         end
      endcase
   end

   // state registers advance once per accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= 1'b1;
         phase_ff <= RX_IDLE;
         cnt_ff   <= 17'd0;
         idx_ff   <= 4'd0;
         shift_ff <= 8'd0;
      end else if (enable) begin
         prev_ff  <= prev_in;
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         idx_ff   <= idx_in;
         shift_ff <= shift_in;
      end
   end

   assign push_out.push = enable && push_c;
   assign push_out.data = shift_in;

endmodule
`default_nettype wire

// ----- hw/rtl/uart8n1_tx.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// uart8n1_tx
// Transmitter: start, eight data bits LSB first and stop, one bit period each.
// ----------------------------------------------------------------------------
module uart8n1_tx
   import uart8n1_pkg::*;
(
   input  wire            clock,
   input  wire            reset,
   input  wire            enable,
   input  wire            write_req,
   input  wire [7:0]      tx_byte,
   input  wire [15:0]     bit_period,
   output tx_status_type  status
);

   logic [9:0]  shift_ff, shift_in;
   logic [15:0] cnt_ff, cnt_in;
   logic [3:0]  left_ff, left_in;
   logic        accepted_c;
   logic [16:0] reload_wide;
   logic [15:0] reload;

   assign reload_wide = at_least_one({1'b0, bit_period});
   assign reload      = reload_wide[15:0];

   // advance the running frame, then take a new write if idle
   always_comb begin
      shift_in   = shift_ff;
      cnt_in     = cnt_ff;
      left_in    = left_ff;
      accepted_c = 1'b0;
      if (left_ff != 4'd0) begin
         cnt_in = cnt_ff - 16'd1;
         if (cnt_in == 16'd0) begin
            shift_in = {1'b0, shift_ff[9:1]};
            left_in  = left_ff - 4'd1;
            cnt_in   = reload;
         end
      end
      if (write_req && left_in == 4'd0) begin
         shift_in   = {1'b1, tx_byte, 1'b0};
         left_in    = 4'd10;
         cnt_in     = reload;
         accepted_c = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= 10'd0;
         cnt_ff   <= 16'd0;
         left_ff  <= 4'd0;
      end else if (enable) begin
         shift_ff <= shift_in;
         cnt_ff   <= cnt_in;
         left_ff  <= left_in;
      end
   end

   assign status.line     = (left_in != 4'd0) ? shift_in[0] : 1'b1;
   assign status.accepted = accepted_c;

endmodule
`default_nettype wire

// ----- hw/rtl/uart_8n1_transceiver_rx_fifo_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// uart_8n1_transceiver_rx_fifo_core
// 8N1 UART transceiver, one tick per beat, receive bytes kept in a ring buffer.
// ----------------------------------------------------------------------------
// a result beat is valid in the cycle after its request beat is taken
// throughput: one beat per cycle unless responses stall; RAM reads and writes
// share a cycle, on distinct entries for valid reads; pop/peek/push never stall
// reset: synchronous, clears pointers, flags, receiver and transmitter state;
// buffer RAM contents are not cleared and are reported only after being written
module uart_8n1_transceiver_rx_fifo_core
   import uart8n1_pkg::*;
#(
   parameter int RX_DEPTH = 64
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output rsp_type     rsp_data,
   input  wire         csr_write_en,
   input  wire         csr_index,
   input  wire [15:0]  csr_wdata
);

   localparam int PW = $clog2(RX_DEPTH);

   logic [15:0]   bit_period_ff;
   logic          rx_enable_ff;
   logic [PW-1:0] rp_ff, rp_in;
   logic [PW-1:0] wp_ff, wp_in;
   logic          overflow_ff, overflow_in;

   logic          accept;
   logic          rd_req, rd_hit, wr_en;
   logic [PW-1:0] rp_next, wp_next;
   logic [15:0]   count_wide;
   logic [7:0]    ram_q;

   rx_push_type   rx_push;
   tx_status_type tx_stat;

   logic          rsp_valid_ff;
   logic          tx_line_ff, read_valid_ff, accepted_ff, ovf_out_ff;
   logic [5:0]    count_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_period_ff <= BIT_PERIOD_RESET;
         rx_enable_ff  <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_BIT_PERIOD: bit_period_ff <= csr_wdata;
            CSR_RX_ENABLE:  rx_enable_ff  <= csr_wdata[0];
            default:        bit_period_ff <= bit_period_ff;
         endcase
      end
   end

   uart8n1_tx u_tx (
      .clock      (clock),
      .reset      (reset),
      .enable     (accept),
      .write_req  (req_data.opcode == OP_WRITE),
      .tx_byte    (req_data.tx_byte),
      .bit_period (bit_period_ff),
      .status     (tx_stat)
   );

   uart8n1_rx u_rx (
      .clock      (clock),
      .reset      (reset),
      .enable     (accept),
      .rx_level   (req_data.rx_level),
      .bit_period (bit_period_ff),
      .rx_enable  (rx_enable_ff),
      .push_out   (rx_push)
   );

   // ring pointers: reads see the buffer before this tick, push comes after
   assign rd_req  = req_data.opcode inside {OP_POP, OP_PEEK};
   assign rd_hit  = rd_req && (rp_ff != wp_ff);
   assign rp_next = (rp_ff == PW'(RX_DEPTH - 1)) ? '0 : rp_ff + 1'b1;
   assign wp_next = (wp_ff == PW'(RX_DEPTH - 1)) ? '0 : wp_ff + 1'b1;

   always_comb begin
      rp_in       = (rd_hit && req_data.opcode == OP_POP) ? rp_next : rp_ff;
      wp_in       = wp_ff;
      overflow_in = overflow_ff;
      wr_en       = 1'b0;
      if (rx_push.push) begin
         if (wp_next != rp_in) begin
            wr_en = 1'b1;
            wp_in = wp_next;
         end else begin
            overflow_in = 1'b1;
         end
      end
   end

   // occupancy after this tick
   always_comb begin
      if (wp_in >= rp_in) begin
         count_wide = 16'(wp_in) - 16'(rp_in);
      end else begin
         count_wide = 16'(wp_in) + 16'(RX_DEPTH) - 16'(rp_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff       <= '0;
         wp_ff       <= '0;
         overflow_ff <= 1'b0;
      end else if (accept) begin
         rp_ff       <= rp_in;
         wp_ff       <= wp_in;
         overflow_ff <= overflow_in;
      end
   end

   // buffer storage; the read register doubles as the result byte
   uart8n1_ram #(
      .WIDTH (8),
      .DEPTH (RX_DEPTH)
   ) u_buf (
      .clock (clock),
      .we    (wr_en),
      .waddr (wp_ff),
      .wdata (rx_push.data),
      .re    (accept),
      .raddr (rp_ff),
      .rdata (ram_q)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tx_line_ff    <= tx_stat.line;
         read_valid_ff <= rd_hit;
         count_ff      <= count_wide[5:0];
         ovf_out_ff    <= overflow_in;
         accepted_ff   <= tx_stat.accepted;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_data.tx_line        = tx_line_ff;
   assign rsp_data.read_data      = read_valid_ff ? ram_q : 8'd0;
   assign rsp_data.read_valid     = read_valid_ff;
   assign rsp_data.rx_count       = count_ff;
   assign rsp_data.overflow       = ovf_out_ff;
   assign rsp_data.write_accepted = accepted_ff;

   // overflow stays set once raised
   a_overflow_sticky: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |=> overflow_ff)
      else $error("overflow flag cleared without reset");

   // a pop or peek on a non-empty buffer reports a byte in its result
   a_read_reported: assert property (@(posedge clock) disable iff (reset)
      (accept && rd_hit) |=> (rsp_valid && rsp_data.read_valid))
      else $error("buffered byte not reported");

   // an accepted write shows the start bit on the same result
   a_start_bit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && accepted_ff) |-> !tx_line_ff)
      else $error("accepted write without start bit");

   // a push never lands on the entry of a reported pop or peek
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (wr_en && accept && rd_hit) |-> (wp_ff != rp_ff))
      else $error("buffer write and read hit the same entry");

   // pointers stay inside the ring
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (32'(rp_ff) < RX_DEPTH) && (32'(wp_ff) < RX_DEPTH))
      else $error("ring pointer out of range");

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 8N1 transceiver core. Every request beat is one
// tick of the serial line; a cycle-level model of the transmitter, receiver
// and receive ring predicts the response beat of each tick. Serial frames are
// built on rx_level with random content, bit lengths and noise, while random
// writes, pops and peeks run alongside and both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top
   import uart8n1_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // ring depth of the instance, pointers wrap at 6 bits
   localparam int RING_DEPTH = 64;

   typedef enum logic [1:0] {RX_IDLE, RX_FIRST, RX_BITS, RX_REARM} rx_phase_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write_en = 1'b0;
   logic        csr_index = 1'b0;
   logic [15:0] csr_wdata = 16'd0;

   // line model state
   logic [15:0] cfg_bit_period = BIT_PERIOD_RESET;
   logic        cfg_rx_on = 1'b0;
   logic        line_prev = 1'b1;
   rx_phase_type rx_phase = RX_IDLE;
   int          rx_wait = 0;
   int          rx_bits = 0;
   logic [7:0]  rx_byte = 8'h00;
   logic [7:0]  rx_ring [RING_DEPTH];
   logic [5:0]  rd_ptr = 6'd0;
   logic [5:0]  wr_ptr = 6'd0;
   logic        overflow_seen = 1'b0;
   logic [9:0]  tx_frame = 10'd0;
   int          tx_wait = 0;
   int          tx_left = 0;

   rsp_type     outcome_q [$];
   int unsigned fail_count = 0;
   int unsigned beats_checked = 0;
   int unsigned beats_sent = 0;

   // sender shaping
   int          burst_left = 0;
   logic        gaps_on = 1'b1;
   int          pct_write = 0;
   int          pct_pop = 0;
   int          pct_peek = 0;

   // receiver stall pattern and long hold-off
   logic [15:0] stall_tick = 16'd0;
   int unsigned hold_asks = 0;
   int unsigned hold_seen = 0;
   int unsigned hold_left = 0;

   uart_8n1_transceiver_rx_fifo_core u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #1 clock = ~clock;

   // a wait of zero ticks lasts one tick
   function automatic int nonzero_wait(input int ticks);
      return (ticks == 0) ? 1 : ticks;
   endfunction

   // advance the line model by one tick and return its response beat
   function automatic rsp_type uart_tick_outcome(input req_type b);
      rsp_type r;
      int      bp;
      logic [5:0] next_wr;
      r = '0;
      bp = cfg_bit_period;
      // transmitter moves on before a new write is looked at
      if (tx_left != 0) begin
         tx_wait = tx_wait - 1;
         if (tx_wait == 0) begin
            tx_frame = tx_frame >> 1;
            tx_left = tx_left - 1;
            tx_wait = nonzero_wait(bp);
         end
      end
      if (b.opcode == OP_WRITE && tx_left == 0) begin
         tx_frame = {1'b1, b.tx_byte, 1'b0};
         tx_left = 10;
         tx_wait = nonzero_wait(bp);
         r.write_accepted = 1'b1;
      end
      r.tx_line = (tx_left != 0) ? tx_frame[0] : 1'b1;
      // reads see the ring before this tick's push
      if ((b.opcode == OP_POP || b.opcode == OP_PEEK) && rd_ptr != wr_ptr) begin
         r.read_data = rx_ring[rd_ptr];
         r.read_valid = 1'b1;
         if (b.opcode == OP_POP) rd_ptr = rd_ptr + 6'd1;
      end
      // receiver
      case (rx_phase)
         RX_IDLE: begin
            if (cfg_rx_on && line_prev && !b.rx_level) begin
               rx_phase = RX_FIRST;
               rx_wait = nonzero_wait(bp + bp / 2);
               rx_bits = 0;
               rx_byte = 8'h00;
            end
         end
         RX_FIRST, RX_BITS: begin
            rx_wait = rx_wait - 1;
            if (rx_wait == 0) begin
               rx_byte = {b.rx_level, rx_byte[7:1]};
               rx_bits = rx_bits + 1;
               if (rx_bits >= 8) begin
                  next_wr = wr_ptr + 6'd1;
                  if (next_wr != rd_ptr) begin
                     rx_ring[wr_ptr] = rx_byte;
                     wr_ptr = next_wr;
                  end else begin
                     overflow_seen = 1'b1;
                  end
                  rx_phase = RX_REARM;
                  rx_wait = nonzero_wait(bp * 3 / 4);
               end else begin
                  rx_phase = RX_BITS;
                  rx_wait = nonzero_wait(bp);
               end
            end
         end
         default: begin
            rx_wait = rx_wait - 1;
            if (rx_wait == 0) rx_phase = RX_IDLE;
         end
      endcase
      line_prev = b.rx_level;
      r.rx_count = wr_ptr - rd_ptr;
      r.overflow = overflow_seen;
      return r;
   endfunction

   task automatic note_failure(input string msg);
      if (fail_count < 10) $display("%s", msg);
      fail_count++;
   endtask

   // predict on every accepted request beat, compare every accepted response beat
   always @(posedge clock) begin : check_beats
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) outcome_q.push_back(uart_tick_outcome(req_data));
         if (rsp_valid && rsp_ready) begin
            if (outcome_q.size() == 0) begin
               note_failure($sformatf("response beat %0d with nothing pending", beats_checked));
            end else begin
               want = outcome_q.pop_front();
               if (rsp_data.tx_line !== want.tx_line ||
                   rsp_data.read_data !== want.read_data ||
                   rsp_data.read_valid !== want.read_valid ||
                   rsp_data.rx_count !== want.rx_count ||
                   rsp_data.overflow !== want.overflow ||
                   rsp_data.write_accepted !== want.write_accepted) begin
                  note_failure($sformatf(
                     "beat %0d line/data/valid/count/ovf/acc exp %b %02h %b %0d %b %b got %b %02h %b %0d %b %b",
                     beats_checked, want.tx_line, want.read_data, want.read_valid,
                     want.rx_count, want.overflow, want.write_accepted,
                     rsp_data.tx_line, rsp_data.read_data, rsp_data.read_valid,
                     rsp_data.rx_count, rsp_data.overflow, rsp_data.write_accepted));
               end
            end
            beats_checked++;
         end
      end
   end

   // response ready: a pattern picked by bits 9:8 of a free-running counter, or a long hold-off
   always @(posedge clock) begin
      stall_tick <= stall_tick + 16'd1;
      if (hold_seen != hold_asks) begin
         hold_seen <= hold_asks;
         hold_left <= 400;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         case (stall_tick[9:8])
            2'd0: rsp_ready <= 1'b1;
            2'd1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2'd2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= stall_tick[2] | stall_tick[0];
         endcase
      end
   end

   // one request beat, with a random gap between bursts
   task automatic send_beat(input logic [1:0] op, input logic [7:0] data, input logic lvl);
      req_type beat;
      int      gap;
      if (gaps_on && burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0
             : $urandom_range(1, ($urandom_range(0, 7) == 0) ? 24 : 5);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 48);
      end
      if (burst_left != 0) burst_left--;
      beat.opcode = op;
      beat.tx_byte = data;
      beat.rx_level = lvl;
      req_valid <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
   endtask

   // one tick of the receive line with an operation from the current mix
   task automatic send_level(input logic lvl);
      int         roll;
      logic [1:0] op;
      roll = $urandom_range(0, 99);
      if (roll < pct_write) op = OP_WRITE;
      else if (roll < pct_write + pct_pop) op = OP_POP;
      else if (roll < pct_write + pct_pop + pct_peek) op = OP_PEEK;
      else op = OP_TICK;
      send_beat(op, 8'($urandom), lvl);
   endtask

   // start, eight data bits lsb first, stop; each bit len ticks give or take jitter
   task automatic send_frame(input logic [7:0] d, input int len, input int jitter);
      logic [9:0] bits;
      int         n;
      bits = {1'b1, d, 1'b0};
      for (int i = 0; i < 10; i++) begin
         n = len - jitter + $urandom_range(0, 2 * jitter);
         if (n < 1) n = 1;
         repeat (n) send_level(bits[i]);
      end
   endtask

   // drop valid and wait for every pending response beat
   task automatic wait_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (outcome_q.size() != 0);
      @(posedge clock);
   endtask

   // idle ticks until the model shows neither a frame in flight nor a receive
   task automatic settle_line();
      wait_results();
      while (rx_phase != RX_IDLE || tx_left != 0) begin
         repeat (8) send_beat(OP_TICK, 8'h00, 1'b1);
         wait_results();
      end
   endtask

   task automatic write_csr(input logic idx, input logic [15:0] value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_BIT_PERIOD) cfg_bit_period = value;
      else cfg_rx_on = value[0];
      @(posedge clock);
   endtask

   // reset defaults, reads of an empty ring, then sets the bit period and enables receive
   task automatic test_empty_reads();
      send_beat(OP_TICK, 8'h00, 1'b1);
      send_beat(OP_PEEK, 8'hFF, 1'b1);
      send_beat(OP_POP, 8'h00, 1'b1);
      wait_results();
      write_csr(CSR_BIT_PERIOD, 16'd1);
      write_csr(CSR_RX_ENABLE, 16'd1);
   endtask

   // writes while busy are refused, one on the closing tick of a frame is taken
   task automatic test_transmit_busy();
      send_beat(OP_WRITE, 8'hFF, 1'b1);
      repeat (11) send_beat(OP_WRITE, 8'h00, 1'b1);
      settle_line();
   endtask

   // peek and pop on the tick of a push see the ring as it was
   task automatic test_receive_order();
      logic [9:0] frame;
      frame = {1'b1, 8'h81, 1'b0};
      for (int i = 0; i < 10; i++) send_beat((i == 8) ? OP_PEEK : OP_TICK, 8'h00, frame[i]);
      frame = {1'b1, 8'h7E, 1'b0};
      for (int i = 0; i < 10; i++) send_beat((i == 8) ? OP_POP : OP_TICK, 8'h00, frame[i]);
      send_beat(OP_PEEK, 8'h00, 1'b1);
      send_beat(OP_POP, 8'h00, 1'b1);
      send_beat(OP_POP, 8'h00, 1'b1);
      settle_line();
   endtask

   // disabling mid-byte finishes that byte, later frames are ignored
   task automatic test_receive_disable();
      logic [9:0] frame;
      write_csr(CSR_BIT_PERIOD, 16'd2);
      frame = {1'b1, 8'h5A, 1'b0};
      for (int i = 0; i < 20; i++) begin
         if (i == 8) begin
            wait_results();
            write_csr(CSR_RX_ENABLE, 16'd0);
         end
         send_beat(OP_TICK, 8'h00, frame[i / 2]);
      end
      send_frame(8'hC3, 2, 0);
      send_beat(OP_PEEK, 8'h00, 1'b1);
      send_beat(OP_POP, 8'h00, 1'b1);
      send_beat(OP_POP, 8'h00, 1'b1);
      wait_results();
      write_csr(CSR_RX_ENABLE, 16'd1);
   endtask

   // zero bit period: every wait is one tick
   task automatic test_tiny_period();
      settle_line();
      write_csr(CSR_BIT_PERIOD, 16'd0);
      send_beat(OP_WRITE, 8'h3C, 1'b1);
      send_frame(8'h3C, 1, 0);
      send_beat(OP_POP, 8'h00, 1'b1);
      settle_line();
      write_csr(CSR_BIT_PERIOD, 16'd1);
   endtask

   // fill the ring past capacity, then drain it with peeks between pops
   task automatic test_buffer_overflow();
      repeat (66) send_frame(8'($urandom), 1, 0);
      for (int i = 0; i < 80; i++)
         send_beat((i % 5 == 0) ? OP_PEEK : OP_POP, 8'($urandom), 1'b1);
      settle_line();
   endtask

   // phases of random settings; mostly clean frames, some wander, noise, cut frames
   task automatic test_random_traffic(input int total);
      int unsigned first;
      int unsigned phase_end;
      int          len;
      int          roll;
      logic [15:0] period;
      first = beats_sent;
      while (beats_sent - first < total) begin
         settle_line();
         roll = $urandom_range(0, 9);
         if (roll < 6) period = 16'($urandom_range(1, 6));
         else if (roll < 8) period = 16'($urandom_range(7, 16));
         else if (roll < 9) period = 16'($urandom_range(0, 3));
         else period = 16'($urandom_range(20, 28));
         write_csr(CSR_BIT_PERIOD, period);
         write_csr(CSR_RX_ENABLE, ($urandom_range(0, 5) != 0) ? 16'd1 : 16'd0);
         pct_write = $urandom_range(0, 25);
         pct_pop = $urandom_range(0, 25);
         pct_peek = $urandom_range(0, 15);
         len = (period == 16'd0) ? 1 : int'(period);
         phase_end = beats_sent + 150;
         while (beats_sent < phase_end) begin
            roll = $urandom_range(0, 19);
            if (roll < 13) begin
               send_frame(8'($urandom), len, 0);
            end else if (roll < 15) begin
               // bit lengths drift around the nominal period
               send_frame(8'($urandom), len, len / 3);
            end else if (roll < 17) begin
               repeat ($urandom_range(1, 3 * len)) send_level(1'b1);
            end else if (roll < 18) begin
               repeat ($urandom_range(1, 2 * len)) send_level(1'($urandom));
            end else begin
               // start bit followed by garbage instead of a frame
               repeat (len) send_level(1'b0);
               repeat ($urandom_range(1, 4 * len)) send_level(1'($urandom));
            end
         end
      end
   endtask

   // long response hold-off while request beats keep coming without gaps
   task automatic test_backpressure();
      settle_line();
      write_csr(CSR_BIT_PERIOD, 16'd3);
      write_csr(CSR_RX_ENABLE, 16'd1);
      pct_write = 10;
      pct_pop = 15;
      pct_peek = 10;
      gaps_on = 1'b0;
      hold_asks <= hold_asks + 1;
      repeat (5) send_frame(8'($urandom), 3, 0);
      gaps_on = 1'b1;
   endtask

   // largest bit period: start of a frame on both lines, a second write refused
   task automatic test_longest_period();
      settle_line();
      write_csr(CSR_BIT_PERIOD, 16'hFFFF);
      write_csr(CSR_RX_ENABLE, 16'd1);
      send_beat(OP_WRITE, 8'hA5, 1'b1);
      send_beat(OP_WRITE, 8'h5A, 1'b1);
      send_beat(OP_TICK, 8'h00, 1'b0);
      repeat (12) send_level(1'($urandom));
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_reads();
      test_transmit_busy();
      test_receive_order();
      test_receive_disable();
      test_tiny_period();
      test_buffer_overflow();
      test_random_traffic(300);
      test_backpressure();
      test_longest_period();
      wait_results();
      repeat (32) @(posedge clock);
      if (fail_count == 0 && outcome_q.size() == 0) begin
         $display("uart_8n1_transceiver_rx_fifo_core verification clean");
      end else begin
         $display("uart_8n1_transceiver_rx_fifo_core verification failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("uart_8n1_transceiver_rx_fifo_core verification failed");
      $finish;
   end

endmodule
`default_nettype wire

// ----- sim.f -----
hw/rtl/uart8n1_pkg.sv
hw/rtl/uart8n1_ram.sv
hw/rtl/uart8n1_rx.sv
hw/rtl/uart8n1_tx.sv
hw/rtl/uart_8n1_transceiver_rx_fifo_core.sv
tb/tb_top.sv
